// ----- src/prd_pkg.sv -----
// ----------------------------------------------------------------------------
// prd_pkg
// Types and constants shared by the padded record deframer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package prd_pkg;

  localparam int unsigned LEN_W          = 17;
  localparam logic [LEN_W-1:0] MAX_PACKET_BYTES = 17'd65536;

  localparam logic [7:0]  RECORD_TYPE    = 8'h17;
  localparam logic [2:0]  HDR_LEN        = 3'd5;
  localparam logic [2:0]  PREFIX_LEN     = 3'd2;
  localparam int unsigned EARLY_DEPTH    = 7;

  localparam int unsigned MAX_BURST      = 5;
  localparam int unsigned BURST_CNT_W    = $clog2(MAX_BURST + 1);

  localparam int unsigned QUEUE_DEPTH    = 8;
  localparam int unsigned QPTR_W         = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W         = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned CFG_INDEX_W    = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_BYPASS         = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RECORD_WRAPPED = 2'd1;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_PREFIX,
    PH_EMIT,
    PH_BYPASS,
    PH_DRAIN
  } phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       last;
  } result_t;

  typedef struct packed {
    result_t [MAX_BURST-1:0]  slot;
    logic [BURST_CNT_W-1:0]   count;
  } burst_t;

endpackage

`default_nettype wire

// ----- src/prd_parser.sv -----
// ----------------------------------------------------------------------------
// prd_parser
// Per-byte header and length prefix parsing; yields a burst of results.
// ----------------------------------------------------------------------------
`default_nettype none

module prd_parser (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        bypass,
  input  wire logic                        record_wrapped,
  input  wire logic                        accept,
  input  wire logic [7:0]                  data_byte,
  input  wire logic [prd_pkg::LEN_W-1:0]   packet_length,
  output prd_pkg::burst_t                  burst
);

  localparam int unsigned W = prd_pkg::LEN_W;
  localparam logic [prd_pkg::BURST_CNT_W-1:0] BURST_ONE = prd_pkg::BURST_CNT_W'(1);

  prd_pkg::phase_t phase, phase_next;
  logic [W-1:0]    pos, pos_next;
  logic [W-1:0]    total, total_next;
  logic [2:0]      rstart, rstart_next;
  logic [W-1:0]    rsize, rsize_next;
  logic [W-1:0]    rem, rem_next;
  logic            emitted, emitted_next;
  logic [7:0]      early [0:prd_pkg::EARLY_DEPTH-1];

  logic [7:0]      eb [0:7];
  logic [W-1:0]    len;
  logic [15:0]     hdr_len;
  logic [15:0]     plen;
  logic [3:0]      k;
  logic [3:0]      n;
  logic            fresh;
  logic            pkt_end;
  prd_pkg::burst_t burst_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= prd_pkg::PH_IDLE;
      pos     <= '0;
      total   <= '0;
      rstart  <= '0;
      rsize   <= '0;
      rem     <= '0;
      emitted <= 1'b0;
    end else begin
      phase   <= phase_next;
      pos     <= pos_next;
      total   <= total_next;
      rstart  <= rstart_next;
      rsize   <= rsize_next;
      rem     <= rem_next;
      emitted <= emitted_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && pos < W'(prd_pkg::EARLY_DEPTH)) begin
      early[pos[2:0]] <= data_byte;
    end
  end

  always_comb begin
    phase_next   = phase;
    pos_next     = pos;
    total_next   = total;
    rstart_next  = rstart;
    rsize_next   = rsize;
    rem_next     = rem;
    emitted_next = emitted;
    len          = packet_length;
    hdr_len      = '0;
    plen         = '0;
    k            = '0;
    n            = '0;
    fresh        = 1'b0;
    pkt_end      = 1'b0;
    burst_next   = '0;
    for (int i = 0; i < prd_pkg::EARLY_DEPTH; i++) begin
      eb[i] = early[i];
    end
    eb[7] = '0;
    if (pos < W'(prd_pkg::EARLY_DEPTH)) begin
      eb[pos[2:0]] = data_byte;
    end

    if (accept) begin
      if (phase == prd_pkg::PH_IDLE) begin
        if (len == '0) begin
          len = W'(1);
        end else if (len > prd_pkg::MAX_PACKET_BYTES) begin
          len = prd_pkg::MAX_PACKET_BYTES;
        end
        total_next   = len;
        pos_next     = '0;
        emitted_next = 1'b0;
        rstart_next  = '0;
        rsize_next   = '0;
        rem_next     = '0;
        if (bypass) begin
          phase_next = prd_pkg::PH_BYPASS;
        end else if (record_wrapped) begin
          phase_next = prd_pkg::PH_HEADER;
        end else begin
          rsize_next = len;
          phase_next = prd_pkg::PH_PREFIX;
        end
      end

      pkt_end = (W'(1) + pos >= total_next) || (pos == {W{1'b1}});

      if (phase_next == prd_pkg::PH_BYPASS) begin
        burst_next.slot[0].data     = data_byte;
        burst_next.slot[0].has_byte = 1'b1;
        burst_next.slot[0].last     = pkt_end;
        burst_next.count            = BURST_ONE;
        emitted_next                = 1'b1;
      end

      if (phase_next == prd_pkg::PH_HEADER) begin
        if (pos == '0 && !(total_next > W'(prd_pkg::HDR_LEN)
                           && data_byte == prd_pkg::RECORD_TYPE)) begin
          rstart_next = '0;
          rsize_next  = total_next;
          phase_next  = prd_pkg::PH_PREFIX;
        end else if (pos == W'(4)) begin
          hdr_len = {eb[3], eb[4]};
          if ({1'b0, total_next} >= 18'(hdr_len) + 18'(prd_pkg::HDR_LEN)) begin
            rstart_next = prd_pkg::HDR_LEN;
            rsize_next  = W'(hdr_len);
          end else begin
            rstart_next = '0;
            rsize_next  = total_next;
          end
          phase_next = prd_pkg::PH_PREFIX;
        end
      end

      if (phase_next == prd_pkg::PH_PREFIX) begin
        if (rsize_next < W'(prd_pkg::PREFIX_LEN)) begin
          rem_next   = rsize_next;
          phase_next = prd_pkg::PH_EMIT;
          fresh      = 1'b1;
        end else if (pos > W'(rstart_next)) begin
          plen = {eb[rstart_next], eb[3'(rstart_next + 3'd1)]};
          if (18'(plen) + 18'(prd_pkg::PREFIX_LEN) <= {1'b0, rsize_next}) begin
            rstart_next = rstart_next + prd_pkg::PREFIX_LEN;
            rem_next    = W'(plen);
          end else begin
            rem_next    = rsize_next;
          end
          phase_next = prd_pkg::PH_EMIT;
          fresh      = 1'b1;
        end
      end

      if (phase_next == prd_pkg::PH_EMIT) begin
        if (fresh) begin
          k = (pos >= W'(rstart_next)) ? 4'(pos[2:0]) - 4'(rstart_next) + 4'd1 : 4'd0;
          n = (W'(k) < rem_next) ? k : rem_next[3:0];
          for (int i = 0; i < prd_pkg::MAX_BURST; i++) begin
            burst_next.slot[i].data     = eb[3'(rstart_next + 3'(i))];
            burst_next.slot[i].has_byte = 1'b1;
            burst_next.slot[i].last     = (4'(i) + 4'd1 == n) && (W'(n) == rem_next);
          end
          burst_next.count = prd_pkg::BURST_CNT_W'(n);
          rem_next         = rem_next - W'(n);
          if (n != '0) begin
            emitted_next = 1'b1;
          end
        end else if (pos >= W'(rstart_next) && rem_next != '0) begin
          rem_next                    = rem_next - W'(1);
          burst_next.slot[0].data     = data_byte;
          burst_next.slot[0].has_byte = 1'b1;
          burst_next.slot[0].last     = (rem_next == '0);
          burst_next.count            = BURST_ONE;
          emitted_next                = 1'b1;
        end
        if (rem_next == '0) begin
          phase_next = prd_pkg::PH_DRAIN;
        end
      end

      if (pkt_end) begin
        if (!emitted_next && burst_next.count == '0) begin
          burst_next.slot[0].data     = '0;
          burst_next.slot[0].has_byte = 1'b0;
          burst_next.slot[0].last     = 1'b1;
          burst_next.count            = BURST_ONE;
        end
        phase_next = prd_pkg::PH_IDLE;
        pos_next   = '0;
      end else begin
        pos_next   = pos + W'(1);
      end
    end
  end

  assign burst = burst_next;

endmodule

`default_nettype wire

// ----- src/prd_result_queue.sv -----
// ----------------------------------------------------------------------------
// prd_result_queue
// Result queue: bursts of up to five results in, one a cycle out on out_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module prd_result_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire prd_pkg::burst_t push,
  output logic               has_room,
  output logic               out_valid,
  input  wire logic          out_ready,
  output prd_pkg::result_t   head
);

  localparam int unsigned PW = prd_pkg::QPTR_W;
  localparam int unsigned CW = prd_pkg::QCNT_W;

  prd_pkg::result_t mem [0:prd_pkg::QUEUE_DEPTH-1];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign has_room  = (count <= CW'(prd_pkg::QUEUE_DEPTH - prd_pkg::MAX_BURST));
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      count <= count + CW'(push.count) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < prd_pkg::MAX_BURST; i++) begin
      if (prd_pkg::BURST_CNT_W'(i) < push.count) begin
        mem[PW'(wr_ptr + PW'(i))] <= push.slot[i];
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/padded_record_deframer.sv -----
// ----------------------------------------------------------------------------
// padded_record_deframer
// Recovers the payload of a received packet taken one byte per transfer.
//
//   channel  direction  handshake             payload
//   in       sink       in_valid / in_ready   data_byte, packet_length
//   out      source     out_valid / out_ready out_byte, has_byte, last
//   cfg      sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
// One input byte per cycle while in_ready is high; all parsing for a byte
// is done in the cycle it is taken; its results (up to five) are registered
// in an eight-entry result queue. in_ready drops only while fewer than five
// entries are free. Results leave one per cycle while out_ready is high.
// Synchronous reset clears parsing state and the queue; cfg_ready is always 1.
// ----------------------------------------------------------------------------
`default_nettype none

module padded_record_deframer (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [7:0]                        data_byte,
  input  wire logic [prd_pkg::LEN_W-1:0]         packet_length,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [7:0]                             out_byte,
  output logic                                   has_byte,
  output logic                                   last,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [prd_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic                              cfg_data
);

  logic             bypass;
  logic             record_wrapped;
  logic             accept;
  logic             has_room;
  prd_pkg::burst_t  burst;
  prd_pkg::result_t head;

  assign cfg_ready = 1'b1;
  assign in_ready  = has_room;
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      bypass         <= 1'b1;
      record_wrapped <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == prd_pkg::CFG_BYPASS) begin
        bypass <= cfg_data;
      end
      if (cfg_index == prd_pkg::CFG_RECORD_WRAPPED) begin
        record_wrapped <= cfg_data;
      end
    end
  end

  prd_parser u_parser (
    .clk            (clk),
    .rst            (rst),
    .bypass         (bypass),
    .record_wrapped (record_wrapped),
    .accept         (accept),
    .data_byte      (data_byte),
    .packet_length  (packet_length),
    .burst          (burst)
  );

  prd_result_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (burst),
    .has_room  (has_room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign out_byte = head.data;
  assign has_byte = head.has_byte;
  assign last     = head.last;

endmodule

`default_nettype wire
